// ===== rtl/core/climate_relay_cycle_scheduler_top_macros.svh =====
// assertion macros shared by the climate relay cycle scheduler rtl
`ifndef CLIMATE_RELAY_CYCLE_SCHEDULER_TOP_MACROS_SVH
`define CLIMATE_RELAY_CYCLE_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CRCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CRCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/crcs_pkg.sv =====
// types, constants and helpers of the climate relay cycle scheduler
`default_nettype none

package crcs_pkg;

    // configuration port
    localparam int unsigned REG_COUNT = 8;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_TEMP_GOAL     = 3'd0,
        REG_TEMP_BAND     = 3'd1,
        REG_HUMID_GOAL    = 3'd2,
        REG_HUMID_BAND    = 3'd3,
        REG_CYCLE_BASE_MS = 3'd4,
        REG_CYCLE_STEP_MS = 3'd5,
        REG_VENT_PCT_BASE = 3'd6,
        REG_HEAT_PCT_BASE = 3'd7
    } crcs_reg_idx_t;

    // register reset values
    localparam logic [11:0] TEMP_GOAL_RST     = 12'd220;
    localparam logic [8:0]  TEMP_BAND_RST     = 9'd20;
    localparam logic [9:0]  HUMID_GOAL_RST    = 10'd500;
    localparam logic [8:0]  HUMID_BAND_RST    = 9'd100;
    localparam logic [26:0] CYCLE_BASE_MS_RST = 27'd1200000;
    localparam logic [25:0] CYCLE_STEP_MS_RST = 26'd600000;
    localparam logic [6:0]  VENT_PCT_BASE_RST = 7'd30;
    localparam logic [6:0]  HEAT_PCT_BASE_RST = 7'd15;

    // default parameter values
    localparam int unsigned TIME_BITS_DEF     = 32;
    localparam int unsigned VENT_STEP_PCT_DEF = 10;
    localparam int unsigned HEAT_STEP_PCT_DEF = 5;

    // settings limits
    localparam logic signed [8:0]  PCT_MAX   = 9'sd100;
    localparam logic signed [28:0] CYCLE_MAX = 29'sh7FFFFFF;

    // cycle / 100 as (cycle * recip) >> shift, exact for a 27 bit cycle
    localparam logic [27:0] DIV100_RECIP = 28'd171798692;
    localparam int unsigned DIV100_SHIFT = 34;
    localparam int unsigned UNIT_W = 21;
    localparam int unsigned OFFSET_W = 28;

    typedef struct packed {
        logic [11:0] temp_goal;
        logic [8:0]  temp_band;
        logic [9:0]  humid_goal;
        logic [8:0]  humid_band;
        logic [26:0] cycle_base_ms;
        logic [25:0] cycle_step_ms;
        logic [6:0]  vent_pct_base;
        logic [6:0]  heat_pct_base;
    } crcs_cfg_t;

    // cycle start request to the deadline pipeline
    typedef struct packed {
        logic        start;
        logic [26:0] cycle;
        logic [6:0]  vent_pct;
        logic [6:0]  heat_pct;
    } crcs_start_t;

    typedef struct packed {
        logic        ventilation_on;
        logic        heating_on;
        logic        cycle_started;
        logic [26:0] cycle_length;
        logic [6:0]  vent_share;
        logic [6:0]  heat_share;
    } crcs_result_t;

    function automatic logic [6:0] clamp_pct(input logic signed [8:0] p);
        logic [6:0] r;
        if (p < 9'sd0)
            r = 7'd0;
        else if (p > PCT_MAX)
            r = PCT_MAX[6:0];
        else
            r = p[6:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crcs_in_if.sv =====
// tick input channel: valid/ready handshake with the sensor reading
`default_nettype none

interface crcs_in_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] temperature;
    logic [9:0]         humidity;
    logic               sensor_valid;

    modport source (output valid, output temperature, output humidity,
                    output sensor_valid, input ready);
    modport sink   (input valid, input temperature, input humidity,
                    input sensor_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/crcs_out_if.sv =====
// result channel: valid/ready handshake with relay drive and cycle settings
`default_nettype none

interface crcs_out_if;
    logic        valid;
    logic        ready;
    logic        ventilation_on;
    logic        heating_on;
    logic        cycle_started;
    logic [26:0] cycle_length;
    logic [6:0]  vent_share;
    logic [6:0]  heat_share;

    modport source (output valid, output ventilation_on, output heating_on,
                    output cycle_started, output cycle_length, output vent_share,
                    output heat_share, input ready);
    modport sink   (input valid, input ventilation_on, input heating_on,
                    input cycle_started, input cycle_length, input vent_share,
                    input heat_share, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/crcs_regs.sv =====
// apb configuration register file
`default_nettype none

module crcs_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [crcs_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [crcs_pkg::APB_DATA_W-1:0]     pwdata,
    output      logic [crcs_pkg::APB_DATA_W-1:0]     prdata,
    output      logic                                pready,
    output      crcs_pkg::crcs_cfg_t                 cfg
);

    crcs_pkg::crcs_cfg_t   cfg_reg;
    crcs_pkg::crcs_cfg_t   cfg_next;
    crcs_pkg::crcs_reg_idx_t idx;
    logic                  wr_en;

    assign idx    = crcs_pkg::crcs_reg_idx_t'(paddr[crcs_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                crcs_pkg::REG_TEMP_GOAL:     cfg_next.temp_goal     = pwdata[11:0];
                crcs_pkg::REG_TEMP_BAND:     cfg_next.temp_band     = pwdata[8:0];
                crcs_pkg::REG_HUMID_GOAL:    cfg_next.humid_goal    = pwdata[9:0];
                crcs_pkg::REG_HUMID_BAND:    cfg_next.humid_band    = pwdata[8:0];
                crcs_pkg::REG_CYCLE_BASE_MS: cfg_next.cycle_base_ms = pwdata[26:0];
                crcs_pkg::REG_CYCLE_STEP_MS: cfg_next.cycle_step_ms = pwdata[25:0];
                crcs_pkg::REG_VENT_PCT_BASE: cfg_next.vent_pct_base = pwdata[6:0];
                crcs_pkg::REG_HEAT_PCT_BASE: cfg_next.heat_pct_base = pwdata[6:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_goal     <= crcs_pkg::TEMP_GOAL_RST;
            cfg_reg.temp_band     <= crcs_pkg::TEMP_BAND_RST;
            cfg_reg.humid_goal    <= crcs_pkg::HUMID_GOAL_RST;
            cfg_reg.humid_band    <= crcs_pkg::HUMID_BAND_RST;
            cfg_reg.cycle_base_ms <= crcs_pkg::CYCLE_BASE_MS_RST;
            cfg_reg.cycle_step_ms <= crcs_pkg::CYCLE_STEP_MS_RST;
            cfg_reg.vent_pct_base <= crcs_pkg::VENT_PCT_BASE_RST;
            cfg_reg.heat_pct_base <= crcs_pkg::HEAT_PCT_BASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // zero-extended readback
    always_comb
    begin
        case (idx)
            crcs_pkg::REG_TEMP_GOAL:     prdata = {20'd0, cfg_reg.temp_goal};
            crcs_pkg::REG_TEMP_BAND:     prdata = {23'd0, cfg_reg.temp_band};
            crcs_pkg::REG_HUMID_GOAL:    prdata = {22'd0, cfg_reg.humid_goal};
            crcs_pkg::REG_HUMID_BAND:    prdata = {23'd0, cfg_reg.humid_band};
            crcs_pkg::REG_CYCLE_BASE_MS: prdata = {5'd0, cfg_reg.cycle_base_ms};
            crcs_pkg::REG_CYCLE_STEP_MS: prdata = {6'd0, cfg_reg.cycle_step_ms};
            crcs_pkg::REG_VENT_PCT_BASE: prdata = {25'd0, cfg_reg.vent_pct_base};
            crcs_pkg::REG_HEAT_PCT_BASE: prdata = {25'd0, cfg_reg.heat_pct_base};
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/crcs_tick.sv =====
// tick logic: deadline checks, relay state and new cycle settings
`default_nettype none

module crcs_tick #(
    parameter int unsigned TIME_BITS     = crcs_pkg::TIME_BITS_DEF,
    parameter int unsigned VENT_STEP_PCT = crcs_pkg::VENT_STEP_PCT_DEF,
    parameter int unsigned HEAT_STEP_PCT = crcs_pkg::HEAT_STEP_PCT_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     fire,
    input  wire logic signed [11:0]       temperature,
    input  wire logic [9:0]               humidity,
    input  wire logic                     sensor_valid,
    input  wire crcs_pkg::crcs_cfg_t      cfg,
    input  wire logic [TIME_BITS-1:0]     vent_dl,
    input  wire logic [TIME_BITS-1:0]     heat_dl,
    output      crcs_pkg::crcs_result_t   res,
    output      crcs_pkg::crcs_start_t    start,
    output      logic [TIME_BITS-1:0]     now
);

    localparam logic signed [8:0] VSTEP = 9'(VENT_STEP_PCT);
    localparam logic signed [8:0] HSTEP = 9'(HEAT_STEP_PCT);

    logic [TIME_BITS-1:0] now_reg,      now_next;
    logic [TIME_BITS-1:0] cycle_dl_reg, cycle_dl_next;
    logic                 vent_armed_reg, vent_armed_next;
    logic                 heat_armed_reg, heat_armed_next;
    logic                 vent_relay_reg, vent_relay_next;
    logic                 heat_relay_reg, heat_relay_next;
    logic [26:0]          cur_cycle_reg,  cur_cycle_next;
    logic [6:0]           cur_vent_reg,   cur_vent_next;
    logic [6:0]           cur_heat_reg,   cur_heat_next;

    logic signed [13:0] t_val, t_hi, t_lo;
    logic [10:0]        h_hi;
    logic signed [11:0] h_lo;
    logic               hot, cold, wet, dry;
    logic signed [28:0] cyc_sum;
    logic signed [8:0]  vp_sum, hp_sum;
    logic [26:0]        new_cycle;
    logic [6:0]         new_vent, new_heat;
    logic               vent_due, heat_due, cycle_due, start_now;

    // band edges and band comparisons
    always_comb
    begin
        t_val = 14'(temperature);
        t_hi  = $signed({{2{cfg.temp_goal[11]}}, cfg.temp_goal})
              + $signed({5'd0, cfg.temp_band});
        t_lo  = $signed({{2{cfg.temp_goal[11]}}, cfg.temp_goal})
              - $signed({5'd0, cfg.temp_band});
        h_hi  = {1'b0, cfg.humid_goal} + {2'b0, cfg.humid_band};
        h_lo  = $signed({2'b0, cfg.humid_goal}) - $signed({3'b0, cfg.humid_band});
        hot   = t_val >= t_hi;
        cold  = t_val <= t_lo;
        wet   = {1'b0, humidity} >= h_hi;
        dry   = $signed({2'b0, humidity}) <= h_lo;
    end

    // new cycle settings
    always_comb
    begin
        cyc_sum = $signed({2'b0, cfg.cycle_base_ms});
        vp_sum  = $signed({2'b0, cfg.vent_pct_base});
        hp_sum  = $signed({2'b0, cfg.heat_pct_base});
        if (sensor_valid)
        begin
            if (hot)
                cyc_sum = cyc_sum + $signed({3'b0, cfg.cycle_step_ms});
            else if (cold)
                cyc_sum = cyc_sum - $signed({3'b0, cfg.cycle_step_ms});
            if (wet)
            begin
                vp_sum = vp_sum + VSTEP;
                if (cold)
                    hp_sum = hp_sum + HSTEP;
            end
            else if (dry)
            begin
                vp_sum = vp_sum - VSTEP;
                if (cold)
                    hp_sum = hp_sum - HSTEP;
            end
        end
        if (cyc_sum < 29'sd0)
            new_cycle = '0;
        else if (cyc_sum > crcs_pkg::CYCLE_MAX)
            new_cycle = crcs_pkg::CYCLE_MAX[26:0];
        else
            new_cycle = cyc_sum[26:0];
        new_vent = crcs_pkg::clamp_pct(vp_sum);
        new_heat = crcs_pkg::clamp_pct(hp_sum);
    end

    // deadline checks in priority order
    assign vent_due  = vent_armed_reg && (now_reg >= vent_dl);
    assign heat_due  = heat_armed_reg && (now_reg >= heat_dl);
    assign cycle_due = now_reg >= cycle_dl_reg;
    assign start_now = !vent_due && !heat_due && cycle_due;

    always_comb
    begin
        now_next        = now_reg + TIME_BITS'(1);
        cycle_dl_next   = cycle_dl_reg;
        vent_armed_next = vent_armed_reg;
        heat_armed_next = heat_armed_reg;
        vent_relay_next = vent_relay_reg;
        heat_relay_next = heat_relay_reg;
        cur_cycle_next  = cur_cycle_reg;
        cur_vent_next   = cur_vent_reg;
        cur_heat_next   = cur_heat_reg;
        if (vent_due)
        begin
            vent_armed_next = 1'b0;
            vent_relay_next = 1'b0;
            heat_relay_next = 1'b1;
        end
        else if (heat_due)
        begin
            heat_armed_next = 1'b0;
            heat_relay_next = 1'b0;
        end
        else if (cycle_due)
        begin
            cur_cycle_next  = new_cycle;
            cur_vent_next   = new_vent;
            cur_heat_next   = new_heat;
            cycle_dl_next   = now_reg + TIME_BITS'(new_cycle);
            vent_armed_next = 1'b1;
            heat_armed_next = 1'b1;
            vent_relay_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            cycle_dl_reg   <= '0;
            vent_armed_reg <= 1'b0;
            heat_armed_reg <= 1'b0;
            vent_relay_reg <= 1'b0;
            heat_relay_reg <= 1'b0;
            cur_cycle_reg  <= '0;
            cur_vent_reg   <= '0;
            cur_heat_reg   <= '0;
        end
        else if (fire)
        begin
            now_reg        <= now_next;
            cycle_dl_reg   <= cycle_dl_next;
            vent_armed_reg <= vent_armed_next;
            heat_armed_reg <= heat_armed_next;
            vent_relay_reg <= vent_relay_next;
            heat_relay_reg <= heat_relay_next;
            cur_cycle_reg  <= cur_cycle_next;
            cur_vent_reg   <= cur_vent_next;
            cur_heat_reg   <= cur_heat_next;
        end
    end

    assign res.ventilation_on = vent_relay_next;
    assign res.heating_on     = heat_relay_next;
    assign res.cycle_started  = start_now;
    assign res.cycle_length   = cur_cycle_next;
    assign res.vent_share     = cur_vent_next;
    assign res.heat_share     = cur_heat_next;

    assign start.start    = fire && start_now;
    assign start.cycle    = new_cycle;
    assign start.vent_pct = new_vent;
    assign start.heat_pct = new_heat;
    assign now            = now_reg;

endmodule

`default_nettype wire

// ===== rtl/core/crcs_deadline.sv =====
// three-stage pipeline for the ventilation and heater deadlines
`default_nettype none

module crcs_deadline #(
    parameter int unsigned TIME_BITS = crcs_pkg::TIME_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire crcs_pkg::crcs_start_t  start,
    input  wire logic [TIME_BITS-1:0]   now,
    output      logic [TIME_BITS-1:0]   vent_dl,
    output      logic [TIME_BITS-1:0]   heat_dl,
    output      logic                   busy
);

    localparam int unsigned PROD_W = 27 + 28;

    logic [PROD_W-1:0]              prod;
    logic [crcs_pkg::UNIT_W-1:0]    unit_reg;
    logic [6:0]                     vp1_reg, hp1_reg;
    logic [TIME_BITS-1:0]           base1_reg, base2_reg;
    logic                           s1_vld_reg, s2_vld_reg;
    logic [crcs_pkg::OFFSET_W-1:0]  voff_reg, voff_next;
    logic [crcs_pkg::OFFSET_W-1:0]  hoff_reg, hoff_next;
    logic [TIME_BITS-1:0]           vent_dl_reg, vent_dl_next;
    logic [TIME_BITS-1:0]           heat_dl_reg, heat_dl_next;

    // cycle / 100 by reciprocal multiply
    assign prod = {28'd0, start.cycle} * {27'd0, crcs_pkg::DIV100_RECIP};

    assign voff_next = {7'd0, unit_reg} * {21'd0, vp1_reg};
    assign hoff_next = {7'd0, unit_reg} * {21'd0, hp1_reg};

    assign vent_dl_next = base2_reg + TIME_BITS'(voff_reg);
    assign heat_dl_next = vent_dl_next + TIME_BITS'(hoff_reg);

    always_ff @(posedge clk)
    begin
        unit_reg  <= prod[crcs_pkg::DIV100_SHIFT +: crcs_pkg::UNIT_W];
        vp1_reg   <= start.vent_pct;
        hp1_reg   <= start.heat_pct;
        base1_reg <= now;
        voff_reg  <= voff_next;
        hoff_reg  <= hoff_next;
        base2_reg <= base1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            vent_dl_reg <= '0;
            heat_dl_reg <= '0;
        end
        else
        begin
            s1_vld_reg <= start.start;
            s2_vld_reg <= s1_vld_reg;
            if (s2_vld_reg)
            begin
                vent_dl_reg <= vent_dl_next;
                heat_dl_reg <= heat_dl_next;
            end
        end
    end

    assign vent_dl = vent_dl_reg;
    assign heat_dl = heat_dl_reg;
    assign busy    = s1_vld_reg || s2_vld_reg;

endmodule

`default_nettype wire

// ===== rtl/core/climate_relay_cycle_scheduler_top.sv =====
// top level of the climate relay cycle scheduler
//
// channel   dir  handshake                 payload
// in_ch     in   valid/ready               temperature, humidity, sensor_valid
// out_ch    out  valid/ready               relay drives, cycle_started, settings
// apb       in   psel/penable/pwrite       8 config registers at 4*index
//
// one tick per clock in steady state; a tick that starts a new cycle holds
// in_ch.ready low while the deadline pipeline (divide by 100, two share
// multiplies, deadline add) fills in
// every tick gives exactly one result item, in the cycle after acceptance
// while a result item waits, a new tick is taken only in the cycle it is read
// rst_n is asynchronous, active low; it clears time, deadlines and relays
`default_nettype none

module climate_relay_cycle_scheduler_top #(
    parameter int unsigned TIME_BITS     = crcs_pkg::TIME_BITS_DEF,
    parameter int unsigned VENT_STEP_PCT = crcs_pkg::VENT_STEP_PCT_DEF,
    parameter int unsigned HEAT_STEP_PCT = crcs_pkg::HEAT_STEP_PCT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    crcs_in_if.sink                               in_ch,
    crcs_out_if.source                            out_ch,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [crcs_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [crcs_pkg::APB_DATA_W-1:0]  pwdata,
    output      logic [crcs_pkg::APB_DATA_W-1:0]  prdata,
    output      logic                             pready
);

`include "climate_relay_cycle_scheduler_top_macros.svh"

    crcs_pkg::crcs_cfg_t    cfg;
    crcs_pkg::crcs_result_t res;
    crcs_pkg::crcs_result_t res_reg;
    crcs_pkg::crcs_start_t  start;
    logic [TIME_BITS-1:0]   now;
    logic [TIME_BITS-1:0]   vent_dl;
    logic [TIME_BITS-1:0]   heat_dl;
    logic                   dl_busy;
    logic                   fire;
    logic                   out_vld_reg, out_vld_next;

    crcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crcs_tick #(
        .TIME_BITS     (TIME_BITS),
        .VENT_STEP_PCT (VENT_STEP_PCT),
        .HEAT_STEP_PCT (HEAT_STEP_PCT)
    ) u_tick (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .temperature  (in_ch.temperature),
        .humidity     (in_ch.humidity),
        .sensor_valid (in_ch.sensor_valid),
        .cfg          (cfg),
        .vent_dl      (vent_dl),
        .heat_dl      (heat_dl),
        .res          (res),
        .start        (start),
        .now          (now)
    );

    crcs_deadline #(
        .TIME_BITS (TIME_BITS)
    ) u_deadline (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .now     (now),
        .vent_dl (vent_dl),
        .heat_dl (heat_dl),
        .busy    (dl_busy)
    );

    // take a tick when the result slot frees up and the deadlines are settled
    assign in_ch.ready = (!out_vld_reg || out_ch.ready) && !dl_busy;
    assign fire        = in_ch.valid && in_ch.ready;

    assign out_vld_next = fire || (out_vld_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    // result payload, loaded with each accepted tick
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.ventilation_on = res_reg.ventilation_on;
    assign out_ch.heating_on     = res_reg.heating_on;
    assign out_ch.cycle_started  = res_reg.cycle_started;
    assign out_ch.cycle_length   = res_reg.cycle_length;
    assign out_ch.vent_share     = res_reg.vent_share;
    assign out_ch.heat_share     = res_reg.heat_share;

    // a cycle start stalls input while the deadlines are computed
    `CRCS_ASSERT_NEXT(a_start_stalls, clk, rst_n, fire && start.start,
        !in_ch.ready, "tick accepted while deadlines still pending")

    // a new cycle always turns ventilation on
    `CRCS_ASSERT_SAME(a_start_vent_on, clk, rst_n,
        out_ch.valid && out_ch.cycle_started, out_ch.ventilation_on,
        "cycle started without ventilation on")

    // shares stay clamped
    `CRCS_ASSERT_SAME(a_share_range, clk, rst_n, out_ch.valid,
        (out_ch.vent_share <= 7'd100) && (out_ch.heat_share <= 7'd100),
        "share out of range")

endmodule

`default_nettype wire
